FILE: rtl/color_edge_mask_dilate_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the colour edge mask block
// Short forms for the concurrent checks used by the checker.
// ----------------------------------------------------------------------------
`ifndef COLOR_EDGE_MASK_DILATE_MACROS_SVH
`define COLOR_EDGE_MASK_DILATE_MACROS_SVH

// Condition holds at every edge outside reset
`define CEMD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Antecedent in this cycle implies consequent in the next
`define CEMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/cemd_pkg.sv
// ----------------------------------------------------------------------------
// cemd_pkg
// Shared types and constants of the colour edge mask block.
// ----------------------------------------------------------------------------
package cemd_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int MAX_RADIUS = 8;

  // 12-bit coordinates, wide enough for the largest supported frame (512)
  localparam int COORD_W = 12;
  localparam int RAD_W   = 6;
  localparam int FIFO_DEPTH = 4;

  localparam logic [7:0] THR_RESET = 8'd32;
  localparam logic [3:0] RAD_RESET = 4'd1;
  localparam logic [9:0] FW_RESET  = 10'd512;
  localparam logic [9:0] FH_RESET  = 10'd512;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_RADIUS    = 2'd1,
    REG_WIDTH     = 2'd2,
    REG_HEIGHT    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_MARK  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } cmd_op_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_MK_RD,
    B_MK_WR,
    B_RD_RD,
    B_RD_OUT
  } back_state_t;

  typedef struct packed {
    logic [7:0] threshold;
    logic [3:0] radius;
    logic [9:0] width;
    logic [9:0] height;
  } cfg_t;

  typedef struct packed {
    cmd_op_t            op;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
    logic               in_frame;
  } cmd_t;

endpackage

FILE: rtl/color_edge_mask_dilate.sv
// ----------------------------------------------------------------------------
// color_edge_mask_dilate
// Colour edge detection with a square-dilated one-bit outline mask.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): kind 0 pushes an RGB pixel in raster
// order, kind 1 reads one mask bit at (read_x, read_y), kind 2 clears the mask
// and restarts the frame. Only reads return a transfer on the out_ channel.
// A pixel push that is no edge leaves the front end without a command. An edge
// queues a mark command; the mask engine pops it, then reads and writes back
// each row of the clipped square in turn (B_MK_RD, B_MK_WR). A read passes
// through the engine in three steps: command pop, row read, output load.
// The mask is a memory of MaxHeight rows of MaxWidth bits with one write and
// one registered read port; that port sets the marking rate.
// A four-entry command queue parts the front end from the engine, so pixels
// keep flowing while marks are written; in_stall rises only when it is full.
// Reset and clear items run a clearing pass over all MaxHeight rows (512 by
// default), one row a cycle; items queue meanwhile. The APB port may be
// written at any time and pready is always high.
// A stalled result holds in the output register; the engine waits there with
// the next read, while pushes continue into the queue.
// ----------------------------------------------------------------------------
module color_edge_mask_dilate #(
  parameter int MaxWidth  = cemd_pkg::MAX_WIDTH,
  parameter int MaxHeight = cemd_pkg::MAX_HEIGHT,
  parameter int MaxRadius = cemd_pkg::MAX_RADIUS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [8:0]  in_read_x,
  input  logic [8:0]  in_read_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  out_pixel_x,
  output logic [8:0]  out_pixel_y,
  output logic        out_outline_mark,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cemd_pkg::cfg_t     cfg_r;
  cemd_pkg::reg_idx_t ridx;
  cemd_pkg::cmd_t     q_in, q_out;
  logic               q_push, q_pop, q_full, q_empty;

  // Register file: four registers at word addresses
  assign pready = 1'b1;
  assign ridx   = cemd_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= cemd_pkg::THR_RESET;
      cfg_r.radius    <= cemd_pkg::RAD_RESET;
      cfg_r.width     <= cemd_pkg::FW_RESET;
      cfg_r.height    <= cemd_pkg::FH_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (ridx)
        cemd_pkg::REG_THRESHOLD: cfg_r.threshold <= pwdata[7:0];
        cemd_pkg::REG_RADIUS:    cfg_r.radius    <= pwdata[3:0];
        cemd_pkg::REG_WIDTH:     cfg_r.width     <= pwdata[9:0];
        cemd_pkg::REG_HEIGHT:    cfg_r.height    <= pwdata[9:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (ridx)
      cemd_pkg::REG_THRESHOLD: prdata = {24'd0, cfg_r.threshold};
      cemd_pkg::REG_RADIUS:    prdata = {28'd0, cfg_r.radius};
      cemd_pkg::REG_WIDTH:     prdata = {22'd0, cfg_r.width};
      cemd_pkg::REG_HEIGHT:    prdata = {22'd0, cfg_r.height};
      default:                 prdata = '0;
    endcase
  end

  // Front end: raster tracking and edge test
  cemd_front #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight),
    .MaxRadius (MaxRadius)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .in_read_x (in_read_x),
    .in_read_y (in_read_y),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  // Command queue
  cemd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Mask engine and result register
  cemd_back #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (q_out),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_outline_mark (out_outline_mark)
  );

endmodule

FILE: rtl/cemd_fifo.sv
// ----------------------------------------------------------------------------
// cemd_fifo
// Short command queue between the classifier and the mask engine.
// ----------------------------------------------------------------------------
module cemd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cemd_pkg::cmd_t push_data,
  input  logic           pop,
  output cemd_pkg::cmd_t pop_data,
  output logic           full,
  output logic           empty
);

  localparam int PtrW = $clog2(cemd_pkg::FIFO_DEPTH);
  localparam int CntW = PtrW + 1;

  cemd_pkg::cmd_t  mem_r [cemd_pkg::FIFO_DEPTH];
  logic [PtrW-1:0] wptr_r, rptr_r;
  logic [CntW-1:0] cnt_r;

  assign full     = (cnt_r == CntW'(cemd_pkg::FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

FILE: rtl/cemd_front.sv
// ----------------------------------------------------------------------------
// cemd_front
// Accept items, track raster position, test for edges, issue commands.
// ----------------------------------------------------------------------------
module cemd_front #(
  parameter int MaxWidth  = cemd_pkg::MAX_WIDTH,
  parameter int MaxHeight = cemd_pkg::MAX_HEIGHT,
  parameter int MaxRadius = cemd_pkg::MAX_RADIUS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cemd_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_kind,
  input  logic [7:0]     in_red,
  input  logic [7:0]     in_green,
  input  logic [7:0]     in_blue,
  input  logic [8:0]     in_read_x,
  input  logic [8:0]     in_read_y,
  input  logic           q_full,
  output logic           q_push,
  output cemd_pkg::cmd_t q_data
);

  localparam int CW = cemd_pkg::COORD_W;

  logic [23:0]   prev_r, prev_nxt;
  logic [CW-1:0] col_r, col_nxt, row_r, row_nxt;

  logic [CW:0]   w, h, col_t, row_t, x1_t, y1_t;
  logic [CW:0]   cx, cy;
  logic [cemd_pkg::RAD_W-1:0] r;
  logic [7:0]    d_r, d_g, d_b;
  logic          edge_hit, accept;
  cemd_pkg::kind_t kind;

  assign kind     = cemd_pkg::kind_t'(in_kind);
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    w = (CW+1)'(cfg.width);
    if (w < (CW+1)'(2))        w = (CW+1)'(2);
    if (w > (CW+1)'(MaxWidth)) w = (CW+1)'(MaxWidth);
    h = (CW+1)'(cfg.height);
    if (h < (CW+1)'(1))         h = (CW+1)'(1);
    if (h > (CW+1)'(MaxHeight)) h = (CW+1)'(MaxHeight);
    r = cemd_pkg::RAD_W'(cfg.radius);
    if (r > cemd_pkg::RAD_W'(MaxRadius)) r = cemd_pkg::RAD_W'(MaxRadius);
  end

  always_comb begin
    d_r = (in_red   > prev_r[23:16]) ? in_red   - prev_r[23:16] : prev_r[23:16] - in_red;
    d_g = (in_green > prev_r[15:8])  ? in_green - prev_r[15:8]  : prev_r[15:8]  - in_green;
    d_b = (in_blue  > prev_r[7:0])   ? in_blue  - prev_r[7:0]   : prev_r[7:0]   - in_blue;
  end

  always_comb begin
    prev_nxt = prev_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    q_push   = 1'b0;
    q_data   = '0;
    edge_hit = 1'b0;
    col_t    = (CW+1)'(col_r);
    row_t    = (CW+1)'(row_r);
    cx       = '0;
    cy       = '0;
    x1_t     = '0;
    y1_t     = '0;
    if (accept) begin
      case (kind)
        cemd_pkg::KIND_PUSH: begin
          // start the next row when a reduced frame left the count too far
          if (col_t >= w) begin
            col_t = '0;
            row_t = row_t + 1'b1;
          end
          if (row_t >= h) row_t = '0;
          edge_hit = (col_t != '0) &&
                     ((d_r >= cfg.threshold) || (d_g >= cfg.threshold) ||
                      (d_b >= cfg.threshold));
          cx   = col_t - 1'b1;
          cy   = row_t;
          x1_t = cx + (CW+1)'(r);
          if (x1_t > w - 1'b1) x1_t = w - 1'b1;
          y1_t = cy + (CW+1)'(r);
          if (y1_t > h - 1'b1) y1_t = h - 1'b1;
          q_push      = edge_hit;
          q_data.op   = cemd_pkg::OP_MARK;
          q_data.x0   = (cx > (CW+1)'(r)) ? CW'(cx - (CW+1)'(r)) : '0;
          q_data.x1   = CW'(x1_t);
          q_data.y0   = (cy > (CW+1)'(r)) ? CW'(cy - (CW+1)'(r)) : '0;
          q_data.y1   = CW'(y1_t);
          prev_nxt    = {in_red, in_green, in_blue};
          col_t = col_t + 1'b1;
          if (col_t >= w) begin
            col_t = '0;
            row_t = row_t + 1'b1;
            if (row_t >= h) row_t = '0;
          end
          col_nxt = CW'(col_t);
          row_nxt = CW'(row_t);
        end
        cemd_pkg::KIND_READ: begin
          q_push          = 1'b1;
          q_data.op       = cemd_pkg::OP_READ;
          q_data.x0       = CW'(in_read_x);
          q_data.y0       = CW'(in_read_y);
          q_data.in_frame = ((CW+1)'(in_read_x) < w) && ((CW+1)'(in_read_y) < h);
        end
        cemd_pkg::KIND_CLEAR: begin
          q_push    = 1'b1;
          q_data.op = cemd_pkg::OP_CLEAR;
          prev_nxt  = '0;
          col_nxt   = '0;
          row_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      col_r  <= '0;
      row_r  <= '0;
    end else begin
      prev_r <= prev_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
    end
  end

endmodule

FILE: rtl/cemd_back.sv
// ----------------------------------------------------------------------------
// cemd_back
// Mask engine: clear sweep, row-wise dilation writes and mask reads.
// ----------------------------------------------------------------------------
module cemd_back #(
  parameter int MaxWidth  = cemd_pkg::MAX_WIDTH,
  parameter int MaxHeight = cemd_pkg::MAX_HEIGHT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  cemd_pkg::cmd_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [8:0]     out_pixel_x,
  output logic [8:0]     out_pixel_y,
  output logic           out_outline_mark
);

  localparam int ColAw = $clog2(MaxWidth);
  localparam int RowAw = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;

  cemd_pkg::back_state_t state_r, state_nxt;
  cemd_pkg::cmd_t        cmd_r;
  logic [RowAw-1:0]      row_r, row_nxt;

  logic [MaxWidth-1:0]   mem [MaxHeight];
  logic [MaxWidth-1:0]   rdata_r, wdata, colmask;
  logic [RowAw-1:0]      waddr, raddr;
  logic                  we, re, out_load, slot_free, last_row;
  logic [ColAw-1:0]      shr;

  logic                  out_valid_r;
  logic [8:0]            px_r, py_r;
  logic                  mark_r;

  assign slot_free = !out_valid_r || !out_stall;
  assign last_row  = (row_r == RowAw'(MaxHeight - 1));
  assign shr       = ColAw'(MaxWidth - 1) - cmd_r.x1[ColAw-1:0];
  assign colmask   = ({MaxWidth{1'b1}} << cmd_r.x0[ColAw-1:0]) &
                     ({MaxWidth{1'b1}} >> shr);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cemd_pkg::B_CLEAR: if (last_row) state_nxt = cemd_pkg::B_IDLE;
      cemd_pkg::B_IDLE: begin
        if (!q_empty) begin
          case (q_data.op)
            cemd_pkg::OP_MARK:  state_nxt = cemd_pkg::B_MK_RD;
            cemd_pkg::OP_READ:  state_nxt = cemd_pkg::B_RD_RD;
            default:            state_nxt = cemd_pkg::B_CLEAR;
          endcase
        end
      end
      cemd_pkg::B_MK_RD: state_nxt = cemd_pkg::B_MK_WR;
      cemd_pkg::B_MK_WR: begin
        if (row_r == cmd_r.y1[RowAw-1:0]) state_nxt = cemd_pkg::B_IDLE;
        else                              state_nxt = cemd_pkg::B_MK_RD;
      end
      cemd_pkg::B_RD_RD:  state_nxt = cemd_pkg::B_RD_OUT;
      cemd_pkg::B_RD_OUT: if (slot_free) state_nxt = cemd_pkg::B_IDLE;
      default:            state_nxt = cemd_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop    = 1'b0;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = row_r;
    raddr    = row_r;
    wdata    = '0;
    out_load = 1'b0;
    row_nxt  = row_r;
    case (state_r)
      cemd_pkg::B_CLEAR: begin
        we      = 1'b1;
        row_nxt = last_row ? '0 : row_r + 1'b1;
      end
      cemd_pkg::B_IDLE: begin
        q_pop   = !q_empty;
        row_nxt = (q_data.op == cemd_pkg::OP_MARK) ? q_data.y0[RowAw-1:0] : '0;
      end
      cemd_pkg::B_MK_RD: re = 1'b1;
      cemd_pkg::B_MK_WR: begin
        we      = 1'b1;
        wdata   = rdata_r | colmask;
        row_nxt = row_r + 1'b1;
      end
      cemd_pkg::B_RD_RD: begin
        re    = 1'b1;
        raddr = cmd_r.y0[RowAw-1:0];
      end
      cemd_pkg::B_RD_OUT: out_load = slot_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_data;
    if (out_load) begin
      px_r   <= cmd_r.x0[8:0];
      py_r   <= cmd_r.y0[8:0];
      mark_r <= cmd_r.in_frame & rdata_r[cmd_r.x0[ColAw-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cemd_pkg::B_CLEAR;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      if (out_load)        out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = px_r;
  assign out_pixel_y      = py_r;
  assign out_outline_mark = mark_r;

endmodule

FILE: rtl/cemd_checker.sv
// ----------------------------------------------------------------------------
// cemd_checker
// Port-level checks on the colour edge mask block, bound to the top level.
// ----------------------------------------------------------------------------
`include "color_edge_mask_dilate_macros.svh"

module cemd_checker #(
  parameter int MaxWidth  = cemd_pkg::MAX_WIDTH,
  parameter int MaxHeight = cemd_pkg::MAX_HEIGHT
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [8:0]  out_pixel_x,
  input logic [8:0]  out_pixel_y,
  input logic        out_outline_mark,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic        pready
);

  logic [9:0]  fw_r, fh_r;
  logic [12:0] wlim, hlim;
  logic        outside;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= cemd_pkg::FW_RESET;
      fh_r <= cemd_pkg::FH_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[3:2] == cemd_pkg::REG_WIDTH)  fw_r <= pwdata[9:0];
      if (paddr[3:2] == cemd_pkg::REG_HEIGHT) fh_r <= pwdata[9:0];
    end
  end

  always_comb begin
    wlim = 13'(fw_r);
    if (wlim < 13'd2)           wlim = 13'd2;
    if (wlim > 13'(MaxWidth))   wlim = 13'(MaxWidth);
    hlim = 13'(fh_r);
    if (hlim < 13'd1)           hlim = 13'd1;
    if (hlim > 13'(MaxHeight))  hlim = 13'(MaxHeight);
    outside = (13'(out_pixel_x) >= wlim) || (13'(out_pixel_y) >= hlim);
  end

  // Hold a stalled result
  `CEMD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_pixel_x) && $stable(out_pixel_y) && $stable(out_outline_mark))

  // Register port never waits
  `CEMD_ASSERT_ALWAYS(a_pready, clk, rst_n, pready)

  // Reads outside the frame return black
  `CEMD_ASSERT_ALWAYS(a_outside_black, clk, rst_n, !(out_valid && outside && out_outline_mark))

endmodule

bind color_edge_mask_dilate cemd_checker #(
  .MaxWidth  (MaxWidth),
  .MaxHeight (MaxHeight)
) u_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Outline mask bench
// Drives pixel, read and clear transfers into the colour edge mask block,
// predicts every returned mask bit from a local model of the dilated mask and
// compares the results in order, over several register settings and idle
// patterns.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 20000;

  // Scoreboard: local copy of mask, counters and registers.
  class mask_scoreboard;
    bit [7:0] threshold;
    bit [3:0] radius;
    bit [9:0] width;
    bit [9:0] height;
    bit [23:0] prev_rgb;
    int unsigned col;
    int unsigned row;
    bit mask [cemd_pkg::MAX_WIDTH*cemd_pkg::MAX_HEIGHT];
    bit [18:0] pending_q [$];
    int errors;

    function void restart();
      prev_rgb = '0;
      col = 0;
      row = 0;
      foreach (mask[i]) mask[i] = 1'b0;
    endfunction

    function void write_reg(cemd_pkg::reg_idx_t idx, bit [31:0] val);
      case (idx)
        cemd_pkg::REG_THRESHOLD: threshold = val[7:0];
        cemd_pkg::REG_RADIUS:    radius = val[3:0];
        cemd_pkg::REG_WIDTH:     width = val[9:0];
        cemd_pkg::REG_HEIGHT:    height = val[9:0];
        default: ;
      endcase
    endfunction

    function int unsigned adiff(bit [7:0] a, bit [7:0] b);
      return (a > b) ? a - b : b - a;
    endfunction

    // Note an accepted input transfer and queue the result it causes.
    function void note_input(bit [1:0] kind, bit [7:0] r, bit [7:0] g, bit [7:0] b,
                             bit [8:0] rx, bit [8:0] ry);
      int unsigned w, h, rad, x0, x1, y0, y1, cx;
      bit m;
      w = (width < 2) ? 2 : (width > cemd_pkg::MAX_WIDTH) ? cemd_pkg::MAX_WIDTH : width;
      h = (height < 1) ? 1 : (height > cemd_pkg::MAX_HEIGHT) ? cemd_pkg::MAX_HEIGHT : height;
      rad = (radius > cemd_pkg::MAX_RADIUS) ? cemd_pkg::MAX_RADIUS : radius;
      case (kind)
        cemd_pkg::KIND_PUSH: begin
          if (col >= w) begin
            col = 0;
            row++;
          end
          if (row >= h) row = 0;
          if (col > 0 && (adiff(prev_rgb[23:16], r) >= threshold ||
                          adiff(prev_rgb[15:8], g) >= threshold ||
                          adiff(prev_rgb[7:0], b) >= threshold)) begin
            cx = col - 1;
            x0 = (cx > rad) ? cx - rad : 0;
            y0 = (row > rad) ? row - rad : 0;
            x1 = (cx + rad > w - 1) ? w - 1 : cx + rad;
            y1 = (row + rad > h - 1) ? h - 1 : row + rad;
            for (int y = y0; y <= y1; y++)
              for (int x = x0; x <= x1; x++) mask[y*cemd_pkg::MAX_WIDTH+x] = 1'b1;
          end
          prev_rgb = {r, g, b};
          col++;
          if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
          end
        end
        cemd_pkg::KIND_READ: begin
          m = (rx < w && ry < h) ? mask[ry*cemd_pkg::MAX_WIDTH+rx] : 1'b0;
          pending_q.push_back({rx, ry, m});
        end
        cemd_pkg::KIND_CLEAR: restart();
        default: ;
      endcase
    endfunction

    // Compare one result transfer with the oldest expectation.
    function void check_result(bit [8:0] px, bit [8:0] py, bit mk);
      bit [18:0] exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d mark=%0d", $time, px, py, mk);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (exp_r != {px, py, mk}) begin
        $display("%0t: mismatch expected x=%0d y=%0d mark=%0d, actual x=%0d y=%0d mark=%0d",
                 $time, exp_r[18:10], exp_r[9:1], exp_r[0], px, py, mk);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = '0;
  logic [7:0] in_red = '0, in_green = '0, in_blue = '0;
  logic [8:0] in_read_x = '0, in_read_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [8:0] out_pixel_x, out_pixel_y;
  logic out_outline_mark;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  mask_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;

  color_edge_mask_dilate uut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Sample results at the rising edge; new stall level goes out at the falling.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_pixel_x, out_pixel_y, out_outline_mark);
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: count cycles with no transfer on either channel and no APB access.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // One APB write: setup cycle, then access cycle.
  task automatic write_reg(cemd_pkg::reg_idx_t idx, bit [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 4'(idx) << 2;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Hold one transfer until accepted; idle gaps before it at random.
  task automatic send(bit [1:0] kind, bit [7:0] r, bit [7:0] g, bit [7:0] b,
                      bit [8:0] rx, bit [8:0] ry);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    in_read_x <= rx;
    in_read_y <= ry;
    do @(posedge clk); while (in_stall);
    sb.note_input(kind, r, g, b, rx, ry);
    @(negedge clk);
  endtask

  task automatic push(bit [7:0] r, bit [7:0] g, bit [7:0] b);
    send(cemd_pkg::KIND_PUSH, r, g, b, 9'($urandom), 9'($urandom));
  endtask

  task automatic read_bit(bit [8:0] x, bit [8:0] y);
    send(cemd_pkg::KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), x, y);
  endtask

  // Drop valid, wait for every expected result, then let the engine drain.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (1000) @(negedge clk);
  endtask

  // Random phase: mostly pixel rows with edges, reads near the frame in use.
  task automatic random_phase(int n, int wmax, int hmax);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 60)
        push($urandom_range(1) ? 8'($urandom) : 8'h00, 8'($urandom), 8'($urandom));
      else if (k < 95)
        read_bit($urandom_range(1) ? 9'($urandom_range(wmax)) : 9'($urandom),
                 $urandom_range(1) ? 9'($urandom_range(hmax)) : 9'($urandom));
      else if (k < 97)
        send(cemd_pkg::KIND_NONE, 8'($urandom), 8'($urandom), 8'($urandom),
             9'($urandom), 9'($urandom));
      else
        send(cemd_pkg::KIND_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
             9'($urandom), 9'($urandom));
    end
  endtask

  initial begin
    sb.threshold = cemd_pkg::THR_RESET;
    sb.radius = cemd_pkg::RAD_RESET;
    sb.width = cemd_pkg::FW_RESET;
    sb.height = cemd_pkg::FH_RESET;
    sb.restart();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    repeat (600) @(negedge clk);

    // Directed: small frame, edges at both row ends and the last tested column.
    write_reg(cemd_pkg::REG_WIDTH, 10'd8);
    write_reg(cemd_pkg::REG_HEIGHT, 10'd4);
    write_reg(cemd_pkg::REG_RADIUS, 4'd1);
    push(8'hff, 8'hff, 8'hff);
    push(8'h00, 8'h00, 8'h00);
    for (int i = 0; i < 5; i++) push(8'h00, 8'h00, 8'h00);
    push(8'h00, 8'h00, 8'hff);
    push(8'h00, 8'h00, 8'h00);
    push(8'h00, 8'hff, 8'h00);
    read_bit(9'd0, 9'd0);
    read_bit(9'd1, 9'd1);
    read_bit(9'd7, 9'd0);
    read_bit(9'd5, 9'd0);
    read_bit(9'd2, 9'd2);
    read_bit(9'd511, 9'd511);
    send(cemd_pkg::KIND_NONE, 8'hff, 8'hff, 8'hff, 9'd0, 9'd0);
    send(cemd_pkg::KIND_CLEAR, 8'd0, 8'd0, 8'd0, 9'd0, 9'd0);
    read_bit(9'd0, 9'd0);
    drain();
    // Extremes: threshold 0 marks all, radius beyond 8, width and height 0.
    write_reg(cemd_pkg::REG_THRESHOLD, 8'd0);
    write_reg(cemd_pkg::REG_RADIUS, 4'd15);
    write_reg(cemd_pkg::REG_WIDTH, 10'd0);
    write_reg(cemd_pkg::REG_HEIGHT, 10'd0);
    push(8'd1, 8'd2, 8'd3);
    push(8'd1, 8'd2, 8'd3);
    read_bit(9'd0, 9'd0);
    read_bit(9'd1, 9'd0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 50; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 25; stall_pct = 25; end
      endcase
      case (ph)
        0: begin
          write_reg(cemd_pkg::REG_THRESHOLD, 8'd255);
          write_reg(cemd_pkg::REG_RADIUS, 4'd0);
          write_reg(cemd_pkg::REG_WIDTH, 10'd2);
          write_reg(cemd_pkg::REG_HEIGHT, 10'd1);
        end
        7: begin
          write_reg(cemd_pkg::REG_THRESHOLD, 8'd32);
          write_reg(cemd_pkg::REG_RADIUS, 4'd8);
          write_reg(cemd_pkg::REG_WIDTH, 10'd1023);
          write_reg(cemd_pkg::REG_HEIGHT, 10'd512);
        end
        default: begin
          write_reg(cemd_pkg::REG_THRESHOLD, $urandom_range(255));
          write_reg(cemd_pkg::REG_RADIUS, $urandom_range(9));
          write_reg(cemd_pkg::REG_WIDTH, $urandom_range(2, 24));
          write_reg(cemd_pkg::REG_HEIGHT, $urandom_range(1, 16));
        end
      endcase
      random_phase(240, (sb.width > 30) ? 511 : sb.width + 1,
                   (sb.height > 30) ? 511 : sb.height + 1);
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/cemd_pkg.sv
rtl/cemd_fifo.sv
rtl/cemd_front.sv
rtl/cemd_back.sv
rtl/color_edge_mask_dilate.sv
rtl/cemd_checker.sv
bench/tb.sv
